>>> sv/assert_macros.svh
// Assertion macros shared by the deque RTL.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/deq_pkg.sv
// Package for the double-ended queue: sizes, operation and status codes,
// and the store request structs. No dependencies.
package deq_pkg;

   // DEPTH must stay a power of two: addresses wrap by truncation.
   localparam int unsigned DEPTH       = 1024;
   localparam int unsigned DATA_WIDTH  = 32;
   localparam int unsigned ADDR_W      = $clog2(DEPTH);
   localparam int unsigned CNT_W       = ADDR_W + 1;
   localparam int unsigned OP_W        = 3;
   localparam int unsigned STATUS_W    = 2;
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 112;

   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [DATA_WIDTH-1:0] word_type;

   localparam count_type CNT_FULL = count_type'(DEPTH);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_QUERY      = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
      word_type data;
   } wr_req_type;

   typedef struct packed {
      addr_type front_addr;
      addr_type back_addr;
   } rd_req_type;

endpackage

>>> sv/double_ended_queue.sv
// Double-ended queue over a 1024-entry circular store, one operation per beat.
// A request beat passes through the input register, then the result register,
// with the state update done combinationally between them. Throughput: one beat
// per cycle while rsp_tready stays high; a response stall backs up into req_tready.
// Reset (synchronous, active high) empties the queue and drops pending beats;
// store contents are not cleared and need no clearing pass.
`include "assert_macros.svh"

module double_ended_queue import deq_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [2:0] operation, [34:3] value, [39:35] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] popped_value, [63:32] front_value, [95:64] back_value,
   // [106:96] count, [108:107] status, [111:109] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int unsigned RSP_PAD_W =
      RSP_TDATA_W - 3 * DATA_WIDTH - CNT_W - STATUS_W;

   // Input register
   logic                in_vld_ff, in_vld_in;
   logic [OP_W-1:0]     in_op_ff;
   word_type            in_value_ff;

   // Result register
   logic                out_vld_ff, out_vld_in;
   logic [RSP_TDATA_W-1:0] out_data_ff;

   // Queue state: head pointer, count, and cached end words
   addr_type            head_ff, head_in;
   count_type           count_ff, count_in;
   word_type            front_ff, front_in;
   word_type            back_ff, back_in;

   word_type            popped;
   status_type          status;
   word_type            front_out;
   word_type            back_out;
   logic                adv;
   logic                empty;
   logic                full;
   addr_type            tail_next_addr;

   wr_req_type          wr_req;
   rd_req_type          rd_req;
   word_type            inner_front;
   word_type            inner_back;

   // Advance the input beat into the result register when it is free.
   assign adv        = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_FULL);
   // Slot one past the back element, where a push to the back lands.
   assign tail_next_addr = head_ff + count_ff[ADDR_W-1:0];

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tvalid && req_tready) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   // One operation: move the pointer, write at most one slot, and pull the
   // next inner word from the prefetched store reads when an end is popped.
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      front_in    = front_ff;
      back_in     = back_ff;
      popped      = '0;
      status      = ST_OK;
      wr_req.en   = 1'b0;
      wr_req.addr = head_ff;
      wr_req.data = in_value_ff;
      if (adv) begin
         unique case (in_op_ff)
            OP_PUSH_FRONT: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  head_in     = head_ff - addr_type'(1);
                  count_in    = count_ff + count_type'(1);
                  front_in    = in_value_ff;
                  back_in     = empty ? in_value_ff : back_ff;
                  wr_req.en   = 1'b1;
                  wr_req.addr = head_ff - addr_type'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  count_in    = count_ff + count_type'(1);
                  back_in     = in_value_ff;
                  front_in    = empty ? in_value_ff : front_ff;
                  wr_req.en   = 1'b1;
                  wr_req.addr = tail_next_addr;
               end
            end
            OP_POP_FRONT: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  popped   = front_ff;
                  head_in  = head_ff + addr_type'(1);
                  count_in = count_ff - count_type'(1);
                  front_in = (count_ff == count_type'(2)) ? back_ff : inner_front;
               end
            end
            OP_POP_BACK: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  popped   = back_ff;
                  count_in = count_ff - count_type'(1);
                  back_in  = (count_ff == count_type'(2)) ? front_ff : inner_back;
               end
            end
            OP_CLEAR: begin
               head_in  = '0;
               count_in = '0;
            end
            default: begin
               // query and unused codes leave the state alone
            end
         endcase
      end
   end

   // Prefetch the words next to each end of the updated queue.
   assign rd_req.front_addr = head_in + addr_type'(1);
   assign rd_req.back_addr  = head_in + count_in[ADDR_W-1:0] - addr_type'(2);

   assign front_out = (count_in != '0) ? front_in : '0;
   assign back_out  = (count_in != '0) ? back_in  : '0;

   deq_store u_store (
      .clock       (clock),
      .wr_req      (wr_req),
      .rd_req      (rd_req),
      .inner_front (inner_front),
      .inner_back  (inner_back)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         head_ff    <= '0;
         count_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
      end
   end

   // Payload: capture the request beat, hold the end words, load the result.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_op_ff    <= req_tdata[OP_W-1:0];
         in_value_ff <= req_tdata[OP_W +: DATA_WIDTH];
      end
      front_ff <= front_in;
      back_ff  <= back_in;
      if (adv) begin
         out_data_ff <= {{RSP_PAD_W{1'b0}}, status, count_in,
                         back_out, front_out, popped};
      end
   end

   // Count stays within the store size.
   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff <= CNT_FULL, "count exceeds depth")
   // A full status is only reported with a full store.
   `ASSERT_IMPLIES(a_full_status, clock, reset,
      out_vld_ff && (out_data_ff[RSP_TDATA_W-RSP_PAD_W-1 -: STATUS_W] == ST_FULL),
      out_data_ff[3*DATA_WIDTH +: CNT_W] == CNT_FULL, "full status with room left")
   // A successful pop removes exactly one element.
   `ASSERT_NEXT(a_pop_count, clock, reset,
      adv && !empty && ((in_op_ff == OP_POP_FRONT) || (in_op_ff == OP_POP_BACK)),
      count_ff == $past(count_ff) - count_type'(1), "pop did not decrement count")

endmodule

>>> sv/deq_store.sv
// Element store of the deque: one write port, two registered read ports
// with write-through bypass. Depends on deq_pkg.
module deq_store import deq_pkg::*; (
   input  logic       clock,
   input  wr_req_type wr_req,
   input  rd_req_type rd_req,
   output word_type   inner_front,
   output word_type   inner_back
);

   word_type mem [DEPTH];

   word_type rd_front_ff;
   word_type rd_back_ff;
   word_type wr_data_ff;
   logic     byp_front_ff;
   logic     byp_back_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         mem[wr_req.addr] <= wr_req.data;
      end
   end

   // Read old contents; a same-cycle write to the read address wins via bypass.
   always_ff @(posedge clock) begin
      rd_front_ff  <= mem[rd_req.front_addr];
      rd_back_ff   <= mem[rd_req.back_addr];
      wr_data_ff   <= wr_req.data;
      byp_front_ff <= wr_req.en && (wr_req.addr == rd_req.front_addr);
      byp_back_ff  <= wr_req.en && (wr_req.addr == rd_req.back_addr);
   end

   assign inner_front = byp_front_ff ? wr_data_ff : rd_front_ff;
   assign inner_back  = byp_back_ff  ? wr_data_ff : rd_back_ff;

endmodule
